FILE: hdl/edn_pkg.sv
// Package with the shared types, constants and state encoding of the nearest-codeword decoder.
`timescale 1ns / 1ps
package edn_pkg;
   localparam int SYM_BITS = 2;
   localparam int WORD_BITS = 64;
   localparam int LEN_BITS = 6;
   localparam int CNT_BITS = 11;
   localparam int IDX_BITS = 10;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   localparam logic [0:0] CSR_CODE_LEN = 1'b0;
   localparam logic [0:0] CSR_WORDS_IN_USE = 1'b1;

   typedef struct packed {
      logic req_type;
      logic [IDX_BITS-1:0] entry_index;
      logic [WORD_BITS-1:0] word_symbols;
   } req_type_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] best_index;
      logic [WORD_BITS-1:0] best_word;
      logic [LEN_BITS-1:0] best_distance;
      logic exact_hit;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HIT_RD, ST_HIT_CMP, ST_ED_RD, ST_ED_ROW, ST_ED_DONE, ST_FETCH, ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic addr_clear;
      logic addr_inc;
      logic addr_best;
      logic row_init;
      logic row_step;
      logic best_init;
      logic best_update;
      logic mark_hit;
      logic respond;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_entry;
      logic match;
      logic last_row;
      logic improves;
      logic close_enough;
   } status_type;
endpackage

FILE: hdl/edn_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module edn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/edn_ctrl.sv
// Controller state machine sequencing the exact-match scan and the edit-distance scan.
`timescale 1ns / 1ps
module edn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  is_decode,
   input  edn_pkg::status_type   status,
   output edn_pkg::ctrl_type     ctrl,
   output logic                  busy
);
   edn_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      busy = (state_ff != edn_pkg::ST_IDLE);
      case (state_ff)
         edn_pkg::ST_IDLE: begin
            if (start) begin
               ctrl.capture = 1'b1;
               ctrl.addr_clear = 1'b1;
               if (is_decode) begin
                  state_in = edn_pkg::ST_HIT_RD;
               end
            end
         end
         edn_pkg::ST_HIT_RD: begin
            state_in = edn_pkg::ST_HIT_CMP;
         end
         edn_pkg::ST_HIT_CMP: begin
            if (status.match) begin
               ctrl.mark_hit = 1'b1;
               ctrl.addr_best = 1'b1;
               state_in = edn_pkg::ST_FETCH;
            end else if (status.last_entry) begin
               ctrl.addr_clear = 1'b1;
               ctrl.best_init = 1'b1;
               state_in = edn_pkg::ST_ED_RD;
            end else begin
               ctrl.addr_inc = 1'b1;
               state_in = edn_pkg::ST_HIT_RD;
            end
         end
         edn_pkg::ST_ED_RD: begin
            ctrl.row_init = 1'b1;
            state_in = edn_pkg::ST_ED_ROW;
         end
         edn_pkg::ST_ED_ROW: begin
            ctrl.row_step = 1'b1;
            if (status.last_row) begin
               state_in = edn_pkg::ST_ED_DONE;
            end
         end
         edn_pkg::ST_ED_DONE: begin
            if (status.improves) begin
               ctrl.best_update = 1'b1;
            end
            if ((status.improves && status.close_enough) || status.last_entry) begin
               state_in = edn_pkg::ST_FETCH;
            end else begin
               ctrl.addr_inc = 1'b1;
               state_in = edn_pkg::ST_ED_RD;
            end
         end
         edn_pkg::ST_FETCH: begin
            ctrl.addr_best = 1'b1;
            state_in = edn_pkg::ST_RESULT;
         end
         edn_pkg::ST_RESULT: begin
            ctrl.respond = 1'b1;
            state_in = edn_pkg::ST_IDLE;
         end
         default: begin
            state_in = edn_pkg::ST_IDLE;
         end
      endcase
   end
endmodule

FILE: hdl/edn_datapath.sv
// Datapath: codebook memory, match compare, one anti-diagonal of the edit-distance table per cycle.
`timescale 1ns / 1ps
module edn_datapath #(
   parameter int MAX_SYMBOLS = 32,
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  edn_pkg::ctrl_type            ctrl,
   input  edn_pkg::req_type_type        req,
   input  logic [edn_pkg::LEN_BITS-1:0] code_len,
   input  logic [edn_pkg::CNT_BITS-1:0] words_in_use,
   output edn_pkg::status_type          status,
   output logic                         rsp_valid,
   output edn_pkg::rsp_type             rsp
);
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RAM_DEPTH = (MAX_ENTRIES > 1) ? MAX_ENTRIES : 2;
   localparam int CW = edn_pkg::CNT_BITS;
   localparam int LW = edn_pkg::LEN_BITS;
   localparam int WB = edn_pkg::WORD_BITS;
   localparam int SB = edn_pkg::SYM_BITS;
   localparam int NC = MAX_SYMBOLS + 1;
   localparam int DW = LW + 1;

   logic [LW-1:0] n_eff;
   logic [CW-1:0] count_eff;
   logic [WB-1:0] mask;
   logic [WB-1:0] rx_ff;
   logic [CW-1:0] addr_ff, addr_in;
   logic [CW-1:0] best_entry_ff;
   logic [LW-1:0] best_dist_ff;
   logic hit_ff;
   logic [LW-1:0] diag1_ff [NC];
   logic [LW-1:0] diag2_ff [NC];
   logic [LW-1:0] diag_in [NC];
   logic [SB-1:0] sym_ff [NC];
   logic [SB-1:0] sym_in [NC];
   logic [DW-1:0] d_ff;
   logic [WB-1:0] rd_data;
   logic [WB-1:0] cw_ff;
   logic rsp_valid_ff;
   edn_pkg::rsp_type rsp_ff;
   logic load_wr;
   logic [LW-1:0] entry_dist;

   always_comb begin
      if (code_len == '0) n_eff = LW'(1);
      else if (code_len > LW'(MAX_SYMBOLS)) n_eff = LW'(MAX_SYMBOLS);
      else n_eff = code_len;
      if (words_in_use == '0) count_eff = CW'(1);
      else if (32'(words_in_use) > MAX_ENTRIES) count_eff = CW'(MAX_ENTRIES);
      else count_eff = words_in_use;
      for (int k = 0; k < 32; k++) begin
         mask[2*k +: 2] = (k < int'(n_eff)) ? 2'b11 : 2'b00;
      end
   end

   assign load_wr = ctrl.capture && (req.req_type == edn_pkg::REQ_LOAD)
      && (32'(req.entry_index) < MAX_ENTRIES);

   always_comb begin
      addr_in = addr_ff;
      if (ctrl.capture) addr_in = load_wr ? CW'(req.entry_index) : '0;
      else if (ctrl.addr_clear) addr_in = '0;
      else if (ctrl.addr_inc) addr_in = addr_ff + CW'(1);
      else if (ctrl.addr_best) addr_in = best_entry_ff;
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (ctrl.capture) rx_ff <= req.word_symbols;
   end

   edn_ram #(.WIDTH(WB), .DEPTH(RAM_DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (load_wr),
      .addr   (AW'(load_wr ? CW'(req.entry_index) : addr_in)),
      .wr_data(req.word_symbols),
      .rd_data(rd_data)
   );

   // Cell i holds the table entry for received symbol i on the current anti-diagonal. The
   // codeword symbols are shifted through the cells so that each cell compares at a fixed place.
   always_comb begin
      logic [DW-1:0] d_next;
      logic [LW-1:0] cand;
      logic cost;
      d_next = d_ff + DW'(1);
      sym_in[0] = cw_ff[SB-1:0];
      for (int i = 1; i < NC; i++) sym_in[i] = sym_ff[i-1];
      diag_in[0] = LW'(d_next);
      for (int i = 1; i < NC; i++) begin
         cost = (rx_ff[SB*(i-1) +: SB] != sym_in[i]);
         cand = diag2_ff[i-1] + (cost ? LW'(1) : LW'(0));
         if (diag1_ff[i-1] + LW'(1) < cand) cand = diag1_ff[i-1] + LW'(1);
         if (diag1_ff[i] + LW'(1) < cand) cand = diag1_ff[i] + LW'(1);
         diag_in[i] = (DW'(i) == d_next) ? LW'(i) : cand;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.row_init) begin
         cw_ff <= rd_data & mask;
         d_ff <= '0;
         for (int i = 0; i < NC; i++) begin
            diag1_ff[i] <= '0;
            diag2_ff[i] <= '0;
            sym_ff[i] <= '0;
         end
      end else if (ctrl.row_step) begin
         cw_ff <= cw_ff >> SB;
         d_ff <= d_ff + DW'(1);
         for (int i = 0; i < NC; i++) begin
            diag1_ff[i] <= diag_in[i];
            diag2_ff[i] <= diag1_ff[i];
            sym_ff[i] <= sym_in[i];
         end
      end
   end

   assign entry_dist = diag1_ff[n_eff[$clog2(MAX_SYMBOLS+1)-1:0]];

   assign status.last_entry = (addr_ff + CW'(1) >= count_eff);
   assign status.match = ((rd_data & mask) == (rx_ff & mask));
   assign status.last_row = (d_ff + DW'(1) >= {n_eff, 1'b0});
   assign status.improves = (entry_dist < best_dist_ff);
   assign status.close_enough = (entry_dist <= LW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= LW'(17);
         best_entry_ff <= '0;
         hit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.respond;
         if (ctrl.capture) hit_ff <= 1'b0;
         if (ctrl.mark_hit) begin
            hit_ff <= 1'b1;
            best_dist_ff <= '0;
            best_entry_ff <= addr_ff;
         end
         if (ctrl.best_init) begin
            best_dist_ff <= n_eff + LW'(1);
            best_entry_ff <= '0;
         end
         if (ctrl.best_update) begin
            best_dist_ff <= entry_dist;
            best_entry_ff <= addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.respond) begin
         rsp_ff.best_index <= edn_pkg::IDX_BITS'(best_entry_ff);
         rsp_ff.best_word <= rd_data & mask;
         rsp_ff.best_distance <= best_dist_ff;
         rsp_ff.exact_hit <= hit_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
endmodule

FILE: hdl/edit_distance_nearest_codeword.sv
// Top level of the edit-distance nearest-codeword decoder.
`timescale 1ns / 1ps
// A load request writes its entry and leaves the block idle. A decode first scans the entries
// in use for an exact match in states ST_HIT_RD and ST_HIT_CMP, then, if none matches, computes
// the edit distance to each entry, one anti-diagonal of the distance table per cycle, ending
// early at a distance of one; ST_FETCH and ST_RESULT then read the chosen entry and the result
// is shown in the cycle after. The single codebook memory port and the wavefront distance unit
// set this sequence. The result appears on rsp_valid for one cycle and cannot be held off; busy
// falls in the cycle the result is shown, so the next request may be taken then.
module edit_distance_nearest_codeword #(
   parameter int MAX_SYMBOLS = 32,
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  edn_pkg::req_type_type  req_payload,
   output logic                   rsp_valid,
   output edn_pkg::rsp_type       rsp_payload,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   edn_pkg::ctrl_type ctrl;
   edn_pkg::status_type status;
   logic [edn_pkg::LEN_BITS-1:0] code_len_ff;
   logic [edn_pkg::CNT_BITS-1:0] words_in_use_ff;
   logic csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_len_ff <= edn_pkg::LEN_BITS'(16);
         words_in_use_ff <= edn_pkg::CNT_BITS'(1);
      end else if (csr_wr && paddr[1:0] == 2'b00) begin
         case (paddr[2])
            edn_pkg::CSR_CODE_LEN: code_len_ff <= pwdata[edn_pkg::LEN_BITS-1:0];
            edn_pkg::CSR_WORDS_IN_USE: words_in_use_ff <= pwdata[edn_pkg::CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         edn_pkg::CSR_CODE_LEN: prdata = 32'(code_len_ff);
         edn_pkg::CSR_WORDS_IN_USE: prdata = 32'(words_in_use_ff);
         default: prdata = '0;
      endcase
   end

   edn_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .is_decode(req_payload.req_type == edn_pkg::REQ_DECODE),
      .status   (status),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   edn_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS), .MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req         (req_payload),
      .code_len    (code_len_ff),
      .words_in_use(words_in_use_ff),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp_payload)
   );

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without a decode in flight");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result shown for two cycles");
   a_hit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.exact_hit) |-> rsp_payload.best_distance == '0)
      else $error("exact hit with non-zero distance");
endmodule
